// ----- rtl/mmac_pkg.sv -----
// Shared types, constants and helpers for the matrix multiply-accumulate core.
// No dependencies; used by every other file of the block except mmac_ram.
`default_nettype none

package mmac_pkg;

	localparam int MAX_DIM_DEFAULT = 16;
	localparam int DIM_RESET       = 16;

	localparam int OP_W      = 3;
	localparam int ROW_W     = 4;
	localparam int VAL_W     = 48;
	localparam int AB_W      = 16;
	localparam int C_W       = 48;
	localparam int PROD_W    = 2 * AB_W;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W   = 56;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE_A = 3'd0,
		OP_WRITE_B = 3'd1,
		OP_WRITE_C = 3'd2,
		OP_RUN     = 3'd3,
		OP_READ_C  = 3'd4
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_M_ROWS    = 2'd0,
		REG_K_DEPTH   = 2'd1,
		REG_N_COLS    = 2'd2,
		REG_TILE_SIZE = 2'd3
	} reg_idx_t;

	// controller -> datapath
	typedef struct packed {
		logic wr_a;
		logic wr_b;
		logic wr_c;
		logic rd_c;     // read item: fetch C at the item's address
		logic rd_ab;    // one MAC step of a run
		logic first;    // first k of a C element
		logic last;     // last k of a C element
		logic out_load; // move fetched C into the result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_valid;
		logic busy;     // run pipeline still holds work
	} status_t;

	// clamp a write value to Q8.8
	function automatic logic [AB_W-1:0] sat_ab(input logic signed [VAL_W-1:0] v);
		if (v > 48'sd32767) begin
			sat_ab = 16'h7FFF;
		end else if (v < -48'sd32768) begin
			sat_ab = 16'h8000;
		end else begin
			sat_ab = v[AB_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mmac_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mmac_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [ADDR_W-1:0]        waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [ADDR_W-1:0]        raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/mmac_ctrl.sv -----
// Controller: input handshake, configuration registers, run sequencer.
// Depends on mmac_pkg.
`default_nettype none

module mmac_ctrl #(
	parameter int MAX_DIM = mmac_pkg::MAX_DIM_DEFAULT,
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [mmac_pkg::OP_W-1:0]      operation,
	input  wire logic                           cfg_we,
	input  wire logic [mmac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mmac_pkg::CFG_W-1:0]     cfg_wdata,
	input  wire logic                           m_tready,
	input  wire mmac_pkg::status_t              st,
	output mmac_pkg::cmd_t                      cmd,
	output logic      [IDX_W-1:0]               ri,
	output logic      [IDX_W-1:0]               rj,
	output logic      [IDX_W-1:0]               rt
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_RUN   = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [IDX_W-1:0] ml_q, kl_q, nl_q;   // last index in use per dimension
	logic [IDX_W-1:0] i_q, j_q, t_q;
	logic accept, elem_end, run_end;

	// register value -> last index, out-of-range values clamped
	function automatic logic [IDX_W-1:0] dim_last(input logic [mmac_pkg::CFG_W-1:0] v);
		logic [7:0] w;
		w = 8'(v);
		if (w == 8'd0) begin
			dim_last = '0;
		end else if (w > 8'(MAX_DIM)) begin
			dim_last = IDX_W'(MAX_DIM - 1);
		end else begin
			dim_last = IDX_W'(w - 8'd1);
		end
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign elem_end = (t_q == kl_q);
	assign run_end  = elem_end && (j_q == nl_q) && (i_q == ml_q);

	always_comb begin
		cmd          = '0;
		cmd.wr_a     = accept && (operation == mmac_pkg::OP_WRITE_A);
		cmd.wr_b     = accept && (operation == mmac_pkg::OP_WRITE_B);
		cmd.wr_c     = accept && (operation == mmac_pkg::OP_WRITE_C);
		cmd.rd_c     = accept && (operation == mmac_pkg::OP_READ_C);
		cmd.rd_ab    = (state_q == S_RUN);
		cmd.first    = (t_q == '0);
		cmd.last     = elem_end;
		cmd.out_load = (state_q == S_READ) && (!st.out_valid || m_tready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && operation == mmac_pkg::OP_READ_C) begin
					state_d = S_READ;
				end else if (accept && operation == mmac_pkg::OP_RUN) begin
					state_d = S_RUN;
				end
			end
			S_READ: begin
				if (cmd.out_load) begin
					state_d = S_IDLE;
				end
			end
			S_RUN: begin
				if (run_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!st.busy) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ml_q    <= dim_last(mmac_pkg::CFG_W'(mmac_pkg::DIM_RESET));
			kl_q    <= dim_last(mmac_pkg::CFG_W'(mmac_pkg::DIM_RESET));
			nl_q    <= dim_last(mmac_pkg::CFG_W'(mmac_pkg::DIM_RESET));
			i_q     <= '0;
			j_q     <= '0;
			t_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					mmac_pkg::REG_M_ROWS:    ml_q <= dim_last(cfg_wdata);
					mmac_pkg::REG_K_DEPTH:   kl_q <= dim_last(cfg_wdata);
					mmac_pkg::REG_N_COLS:    nl_q <= dim_last(cfg_wdata);
					mmac_pkg::REG_TILE_SIZE: ; // traversal hint only, nothing to hold
					default: ;
				endcase
			end
			if (accept && operation == mmac_pkg::OP_RUN) begin
				i_q <= '0;
				j_q <= '0;
				t_q <= '0;
			end else if (state_q == S_RUN) begin
				if (elem_end) begin
					t_q <= '0;
					if (j_q == nl_q) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end else begin
					t_q <= t_q + 1'b1;
				end
			end
		end
	end

	assign ri = i_q;
	assign rj = j_q;
	assign rt = t_q;

`ifndef NO_ASSERTIONS
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !st.busy)
		else $error("item accepted while run pipeline busy");

	a_read_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && operation == mmac_pkg::OP_READ_C) |=> !s_tready)
		else $error("input not held after read transfer");

	a_read_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ && !st.out_valid) |=> st.out_valid)
		else $error("read result did not reach output register");

	a_drain_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN && !st.busy) |=> s_tready)
		else $error("controller stuck after run drained");
`endif

endmodule

`default_nettype wire

// ----- rtl/mmac_datapath.sv -----
// Datapath: A/B/C element stores, MAC pipeline, saturating update, result register.
// Depends on mmac_pkg and mmac_ram.
`default_nettype none

module mmac_datapath #(
	parameter int MAX_DIM = mmac_pkg::MAX_DIM_DEFAULT,
	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire mmac_pkg::cmd_t                    cmd,
	input  wire logic        [IDX_W-1:0]           ri,
	input  wire logic        [IDX_W-1:0]           rj,
	input  wire logic        [IDX_W-1:0]           rt,
	input  wire logic        [mmac_pkg::ROW_W-1:0] row,
	input  wire logic        [mmac_pkg::ROW_W-1:0] col,
	input  wire logic signed [mmac_pkg::VAL_W-1:0] value,
	input  wire logic                              m_tready,
	output logic                                   out_valid,
	output logic             [mmac_pkg::ROW_W-1:0] out_row,
	output logic             [mmac_pkg::ROW_W-1:0] out_col,
	output logic signed      [mmac_pkg::C_W-1:0]   c_value,
	output mmac_pkg::status_t                      st
);

	localparam int ADDR_W = 2 * IDX_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int SUM_W  = mmac_pkg::PROD_W + IDX_W;
	localparam int CX_W   = mmac_pkg::C_W + 1;

	logic                          in_range;
	logic [ADDR_W-1:0]             item_addr;
	logic [mmac_pkg::AB_W-1:0]     a_rdata, b_rdata;
	logic [mmac_pkg::C_W-1:0]      c_rdata, c_wdata;
	logic [ADDR_W-1:0]             c_waddr, c_raddr;
	logic                          c_we, c_re;

	logic                          v_s1, first_s1, last_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic                          v_s2, first_s2, last_s2;
	logic [ADDR_W-1:0]             addr_s2;
	logic signed [mmac_pkg::PROD_W-1:0] prod_s2;
	logic signed [mmac_pkg::C_W-1:0]    c_s2;
	logic signed [SUM_W-1:0]       acc_q;
	logic                          fin_s3;
	logic [ADDR_W-1:0]             addr_s3;
	logic signed [mmac_pkg::C_W-1:0]    c_s3;
	logic signed [CX_W-1:0]        upd;
	logic signed [mmac_pkg::C_W-1:0]    upd_sat;

	logic [mmac_pkg::ROW_W-1:0]    rd_row_q, rd_col_q;
	logic                          rd_inside_q;

	assign in_range  = (32'(row) < MAX_DIM) && (32'(col) < MAX_DIM);
	assign item_addr = {IDX_W'(row), IDX_W'(col)};

	mmac_ram #(.WIDTH(mmac_pkg::AB_W), .DEPTH(DEPTH)) u_a_ram (
		.clk   (clk),
		.we    (cmd.wr_a && in_range),
		.waddr (item_addr),
		.wdata (mmac_pkg::sat_ab(value)),
		.re    (cmd.rd_ab),
		.raddr ({ri, rt}),
		.rdata (a_rdata)
	);

	mmac_ram #(.WIDTH(mmac_pkg::AB_W), .DEPTH(DEPTH)) u_b_ram (
		.clk   (clk),
		.we    (cmd.wr_b && in_range),
		.waddr (item_addr),
		.wdata (mmac_pkg::sat_ab(value)),
		.re    (cmd.rd_ab),
		.raddr ({rt, rj}),
		.rdata (b_rdata)
	);

	// C port: item writes and run write-backs never overlap
	assign c_we    = fin_s3 || (cmd.wr_c && in_range);
	assign c_waddr = fin_s3 ? addr_s3 : item_addr;
	assign c_wdata = fin_s3 ? upd_sat : value;
	assign c_re    = cmd.rd_c || (cmd.rd_ab && cmd.first);
	assign c_raddr = cmd.rd_c ? item_addr : {ri, rj};

	mmac_ram #(.WIDTH(mmac_pkg::C_W), .DEPTH(DEPTH)) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// C + sum, clipped to 48 bits
	assign upd = CX_W'(c_s3) + CX_W'(acc_q);
	always_comb begin
		if (upd[CX_W-1] != upd[CX_W-2]) begin
			upd_sat = upd[CX_W-1] ? {1'b1, {(mmac_pkg::C_W-1){1'b0}}}
			                      : {1'b0, {(mmac_pkg::C_W-1){1'b1}}};
		end else begin
			upd_sat = upd[mmac_pkg::C_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			fin_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1   <= cmd.rd_ab;
			v_s2   <= v_s1;
			fin_s3 <= v_s2 && last_s2;
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (m_tready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		last_s1  <= cmd.last;
		addr_s1  <= {ri, rj};
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		addr_s2  <= addr_s1;
		addr_s3  <= addr_s2;
		prod_s2  <= $signed(a_rdata) * $signed(b_rdata);
		// C is fetched at k = 0; hold it until the element finishes
		if (v_s1 && first_s1) begin
			c_s2 <= $signed(c_rdata);
		end
		if (v_s2) begin
			acc_q <= first_s2 ? SUM_W'(prod_s2) : acc_q + SUM_W'(prod_s2);
		end
		if (v_s2 && last_s2) begin
			c_s3 <= c_s2;
		end
		if (cmd.rd_c) begin
			rd_row_q    <= row;
			rd_col_q    <= col;
			rd_inside_q <= in_range;
		end
		if (cmd.out_load) begin
			out_row <= rd_row_q;
			out_col <= rd_col_q;
			c_value <= rd_inside_q ? $signed(c_rdata) : '0;
		end
	end

	assign st.out_valid = out_valid;
	assign st.busy      = v_s1 || v_s2 || fin_s3;

endmodule

`default_nettype wire

// ----- rtl/matrix_multiply_accumulate_core.sv -----
// Top level of the fixed-point matrix multiply-accumulate core, C += A x B.
// Depends on mmac_pkg, mmac_ctrl, mmac_datapath (and through it mmac_ram).
`default_nettype none

// Usage
//   Input stream: s_tuser carries the operation (write A, write B, write C,
//   run, read C); s_tdata carries row, column and value. Write items are
//   accepted back to back. A read item returns one transfer on the
//   output stream: out_row, out_col and the 48-bit Q32.16 C element.
//   Read: the fetched C is loaded into the output register once it is free;
//   the input is ready again the cycle after that load, so a new read is
//   taken only after the previous one has been loaded.
//   Run: one MAC step per cycle through the single multiplier; the input
//   stalls while the sequencer walks all m_rows*k_depth*n_cols steps and
//   the three stage MAC/write-back pipeline drains.
//   If the receiver stalls (m_tready low) the result waits in the output
//   register; writes keep flowing, a second read holds until it drains.
//   Configuration (cfg_we/cfg_index/cfg_wdata) is to be written while idle,
//   which the block does not enforce; tile_size is accepted but ignored.
//   Reset: asynchronous, active low; clears control state and sets the
//   dimensions to 16. Element stores are not cleared and hold garbage
//   until written.

module matrix_multiply_accumulate_core #(
	parameter int MAX_DIM = mmac_pkg::MAX_DIM_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [mmac_pkg::TDATA_W-1:0]   s_tdata,   // row[3:0], col[7:4], value[55:8]
	input  wire logic [mmac_pkg::OP_W-1:0]      s_tuser,   // operation[2:0]
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [mmac_pkg::TDATA_W-1:0]   m_tdata,   // out_row[3:0], out_col[7:4], c_value[55:8]
	input  wire logic                           cfg_we,
	input  wire logic [mmac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [mmac_pkg::CFG_W-1:0]     cfg_wdata
);

	localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	mmac_pkg::cmd_t    cmd;
	mmac_pkg::status_t st;
	logic [IDX_W-1:0]  ri, rj, rt;
	logic [mmac_pkg::ROW_W-1:0] out_row, out_col;
	logic signed [mmac_pkg::C_W-1:0] c_value;

	// sequencer walks i, j, k; one MAC step issued per cycle
	mmac_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.operation (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.m_tready  (m_tready),
		.st        (st),
		.cmd       (cmd),
		.ri        (ri),
		.rj        (rj),
		.rt        (rt)
	);

	// stores, multiplier, accumulator, saturating C update, output register
	mmac_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ri        (ri),
		.rj        (rj),
		.rt        (rt),
		.row       (s_tdata[3:0]),
		.col       (s_tdata[7:4]),
		.value     (s_tdata[55:8]),
		.m_tready  (m_tready),
		.out_valid (m_tvalid),
		.out_row   (out_row),
		.out_col   (out_col),
		.c_value   (c_value),
		.st        (st)
	);

	assign m_tdata = {c_value, out_col, out_row};

endmodule

`default_nettype wire

// ----- test/matrix_multiply_accumulate_core_tb.sv -----
// Self-checking bench for matrix_multiply_accumulate_core: streams element writes, runs and reads,
// predicts each C read from a bench-side matrix model or the directed table's expectation,
// and compares each output transfer. Depends on mmac_pkg and the RTL of the core; reads no files.
module matrix_multiply_accumulate_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIM = mmac_pkg::MAX_DIM_DEFAULT;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int PRINT_CAP = 100;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_ITEMS = 100;

	// opcodes with no function; the core must drop them
	localparam logic [mmac_pkg::OP_W-1:0] OP_RSVD_LO = 3'd5;
	localparam logic [mmac_pkg::OP_W-1:0] OP_RSVD_MID = 3'd6;
	localparam logic [mmac_pkg::OP_W-1:0] OP_RSVD_HI = 3'd7;

	localparam logic [mmac_pkg::C_W-1:0] C_MAX48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [mmac_pkg::C_W-1:0] C_MIN48 = 48'h8000_0000_0000;
	localparam longint C_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint C_LO = -C_HI - 1;

	typedef struct {
		logic [mmac_pkg::ROW_W-1:0] row;
		logic [mmac_pkg::ROW_W-1:0] col;
		logic [mmac_pkg::C_W-1:0]   value;
	} c_read_t;

	typedef struct {
		logic [mmac_pkg::OP_W-1:0]  op;
		logic [mmac_pkg::ROW_W-1:0] row;
		logic [mmac_pkg::ROW_W-1:0] col;
		logic [mmac_pkg::VAL_W-1:0] value;
		bit                         typed;
		logic [mmac_pkg::C_W-1:0]   c_exp;
	} dir_row_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [mmac_pkg::TDATA_W-1:0]   s_tdata = '0;
	logic [mmac_pkg::OP_W-1:0]      s_tuser = mmac_pkg::OP_WRITE_A;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [mmac_pkg::TDATA_W-1:0]   m_tdata;
	logic                           cfg_we = 1'b0;
	mmac_pkg::reg_idx_t             cfg_index = mmac_pkg::REG_M_ROWS;
	logic [mmac_pkg::CFG_W-1:0]     cfg_wdata = '0;

	// bench copy of the core's matrices and registers
	logic signed [mmac_pkg::AB_W-1:0] mat_a [DIM*DIM];
	logic signed [mmac_pkg::AB_W-1:0] mat_b [DIM*DIM];
	logic signed [mmac_pkg::C_W-1:0]  mat_c [DIM*DIM];
	logic [mmac_pkg::CFG_W-1:0]       dim_m = 5'd16;
	logic [mmac_pkg::CFG_W-1:0]       dim_k = 5'd16;
	logic [mmac_pkg::CFG_W-1:0]       dim_n = 5'd16;
	logic [mmac_pkg::CFG_W-1:0]       tile = 5'd4;

	c_read_t pending_reads [$];

	int snd_idle_pct = 7;
	int rcv_idle_pct = 79;
	int mismatch_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int reads_sent = 0;
	int runs_sent = 0;
	int settings_used = 0;
	bit run_since_idle = 1'b0;

	// directed walk: extremes, every opcode, saturation both ways, out-of-region C, dead opcodes.
	// Dimensions are m=0 (reads as 1), k=1, n=1 while this runs.
	dir_row_t directed_rows [0:23] = '{
		'{mmac_pkg::OP_WRITE_C, 4'd0,  4'd0,  C_MAX48,            1'b0, 48'd0},
		'{mmac_pkg::OP_READ_C,  4'd0,  4'd0,  48'd0,              1'b1, C_MAX48},
		'{mmac_pkg::OP_WRITE_A, 4'd0,  4'd0,  C_MAX48,            1'b0, 48'd0},
		'{mmac_pkg::OP_WRITE_B, 4'd0,  4'd0,  48'd1000,           1'b0, 48'd0},
		'{mmac_pkg::OP_RUN,     4'd0,  4'd0,  48'd0,              1'b0, 48'd0},
		'{mmac_pkg::OP_READ_C,  4'd0,  4'd0,  48'd0,              1'b1, C_MAX48},
		'{mmac_pkg::OP_WRITE_C, 4'd0,  4'd0,  C_MIN48,            1'b0, 48'd0},
		'{mmac_pkg::OP_WRITE_A, 4'd0,  4'd0,  C_MIN48,            1'b0, 48'd0},
		'{mmac_pkg::OP_WRITE_B, 4'd0,  4'd0,  48'h0000_0000_7FFF, 1'b0, 48'd0},
		'{mmac_pkg::OP_RUN,     4'd0,  4'd0,  48'd0,              1'b0, 48'd0},
		'{mmac_pkg::OP_READ_C,  4'd0,  4'd0,  48'd0,              1'b1, C_MIN48},
		'{mmac_pkg::OP_WRITE_C, 4'd15, 4'd15, 48'h1234_5678_9ABC, 1'b0, 48'd0},
		'{mmac_pkg::OP_RUN,     4'd0,  4'd0,  48'hFFFF_FFFF_FFFF, 1'b0, 48'd0},
		'{mmac_pkg::OP_READ_C,  4'd15, 4'd15, 48'd0,              1'b1, 48'h1234_5678_9ABC},
		'{mmac_pkg::OP_WRITE_C, 4'd0,  4'd0,  48'd0,              1'b0, 48'd0},
		'{mmac_pkg::OP_WRITE_A, 4'd0,  4'd0,  48'd32768,          1'b0, 48'd0},
		'{mmac_pkg::OP_WRITE_B, 4'd0,  4'd0,  48'hFFFF_FFFF_7FFF, 1'b0, 48'd0},
		'{mmac_pkg::OP_RUN,     4'd0,  4'd0,  48'd0,              1'b0, 48'd0},
		'{mmac_pkg::OP_READ_C,  4'd0,  4'd0,  48'd0,              1'b0, 48'd0},
		'{OP_RSVD_LO,           4'd3,  4'd9,  48'h5555_5555_5555, 1'b0, 48'd0},
		'{OP_RSVD_MID,          4'd0,  4'd15, 48'hFFFF_FFFF_FFFF, 1'b0, 48'd0},
		'{OP_RSVD_HI,           4'd15, 4'd15, 48'hAAAA_AAAA_AAAA, 1'b0, 48'd0},
		'{mmac_pkg::OP_READ_C,  4'd15, 4'd15, 48'd0,              1'b1, 48'h1234_5678_9ABC},
		'{mmac_pkg::OP_READ_C,  4'd15, 4'd0,  48'd0,              1'b1, 48'd0}
	};

	// phase settings; a nonzero rand limit draws m, k, n from 1..limit instead
	int phase_m [NUM_PHASES] = '{1, 16, 0,  0, 4, 0, 16, 0, 2,  0, 31, 0};
	int phase_k [NUM_PHASES] = '{1, 16, 31, 0, 4, 0, 1,  0, 16, 0, 31, 0};
	int phase_n [NUM_PHASES] = '{1, 16, 2,  0, 4, 0, 16, 0, 3,  0, 31, 0};
	int phase_t [NUM_PHASES] = '{1, 16, 0,  2, 4, 9, 31, 3, 7,  1, 31, 5};
	int phase_rand [NUM_PHASES] = '{0, 0, 0, 4, 0, 4, 0, 6, 0, 4, 0, 8};

	matrix_multiply_accumulate_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // row[3:0], col[7:4], value[55:8]
		.s_tuser   (s_tuser),   // operation[2:0]
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // out_row[3:0], out_col[7:4], c_value[55:8]
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// dimension register as the core reads it
	function automatic int eff_dim(input logic [mmac_pkg::CFG_W-1:0] r);
		if (r == 0) return 1;
		if (r > DIM) return DIM;
		return int'(r);
	endfunction

	function automatic logic signed [mmac_pkg::AB_W-1:0] clamp_q88(
			input logic signed [mmac_pkg::VAL_W-1:0] v);
		longint lv;
		lv = v;
		if (lv > 32767) return 16'sh7FFF;
		if (lv < -32768) return 16'sh8000;
		return v[mmac_pkg::AB_W-1:0];
	endfunction

	// apply one accepted input transfer to the bench matrices; a C read yields its expectation
	task automatic apply_to_matrices(input logic [mmac_pkg::OP_W-1:0] op,
			input logic [mmac_pkg::ROW_W-1:0] r, input logic [mmac_pkg::ROW_W-1:0] c,
			input logic [mmac_pkg::VAL_W-1:0] v,
			output bit is_read, output c_read_t rd);
		int idx, m, k, n;
		longint sum, acc;
		idx = int'(r) * DIM + int'(c);
		is_read = 1'b0;
		rd.row = r;
		rd.col = c;
		rd.value = '0;
		case (op)
			mmac_pkg::OP_WRITE_A: mat_a[idx] = clamp_q88(v);
			mmac_pkg::OP_WRITE_B: mat_b[idx] = clamp_q88(v);
			mmac_pkg::OP_WRITE_C: mat_c[idx] = v;
			mmac_pkg::OP_RUN: begin
				m = eff_dim(dim_m);
				k = eff_dim(dim_k);
				n = eff_dim(dim_n);
				for (int i = 0; i < m; i++) begin
					for (int j = 0; j < n; j++) begin
						sum = 0;
						for (int t = 0; t < k; t++) begin
							sum += longint'(mat_a[i*DIM + t]) * longint'(mat_b[t*DIM + j]);
						end
						acc = mat_c[i*DIM + j];
						acc += sum;
						if (acc > C_HI) begin
							acc = C_HI;
						end else if (acc < C_LO) begin
							acc = C_LO;
						end
						mat_c[i*DIM + j] = acc[mmac_pkg::C_W-1:0];
					end
				end
			end
			mmac_pkg::OP_READ_C: begin
				is_read = 1'b1;
				rd.value = mat_c[idx];
			end
			default: ;  // dead opcodes change nothing
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP) begin
			$display("%0t ns: mismatch: %s", $realtime, msg);
		end
	endtask

	// one input transfer: random sender gap, then hold valid until accepted
	task automatic push_item(input logic [mmac_pkg::OP_W-1:0] op,
			input logic [mmac_pkg::ROW_W-1:0] r, input logic [mmac_pkg::ROW_W-1:0] c,
			input logic [mmac_pkg::VAL_W-1:0] v,
			input bit typed, input logic [mmac_pkg::C_W-1:0] c_exp);
		bit is_read;
		c_read_t rd;
		@(negedge clk);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {v, c, r};
		do begin
			@(posedge clk);
		end while (s_tready !== 1'b1);
		apply_to_matrices(op, r, c, v, is_read, rd);
		if (is_read) begin
			if (typed) rd.value = c_exp;
			pending_reads.push_back(rd);
			reads_sent++;
		end
		if (op == mmac_pkg::OP_RUN) begin
			runs_sent++;
			run_since_idle = 1'b1;
		end
		items_sent++;
	endtask

	// drop valid, let every read come back, then give a run time to finish
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_reads.size() != 0) @(posedge clk);
		if (run_since_idle) begin
			repeat (eff_dim(dim_m) * eff_dim(dim_k) * eff_dim(dim_n) + 32) @(posedge clk);
		end else begin
			repeat (32) @(posedge clk);
		end
		run_since_idle = 1'b0;
	endtask

	task automatic write_reg(input mmac_pkg::reg_idx_t idx,
			input logic [mmac_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			mmac_pkg::REG_M_ROWS:    dim_m = val;
			mmac_pkg::REG_K_DEPTH:   dim_k = val;
			mmac_pkg::REG_N_COLS:    dim_n = val;
			mmac_pkg::REG_TILE_SIZE: tile = val;
			default: ;
		endcase
	endtask

	task automatic set_dims(input int m, input int k, input int n, input int t);
		write_reg(mmac_pkg::REG_M_ROWS, mmac_pkg::CFG_W'(m));
		write_reg(mmac_pkg::REG_K_DEPTH, mmac_pkg::CFG_W'(k));
		write_reg(mmac_pkg::REG_N_COLS, mmac_pkg::CFG_W'(n));
		write_reg(mmac_pkg::REG_TILE_SIZE, mmac_pkg::CFG_W'(t));
		@(negedge clk);
		cfg_we = 1'b0;
		settings_used++;
	endtask

	// mostly inside the region in use, now and then anywhere in the store
	function automatic logic [mmac_pkg::ROW_W-1:0] pick_index(input int lim);
		if ($urandom_range(99) < 80) return mmac_pkg::ROW_W'($urandom_range(lim - 1));
		return mmac_pkg::ROW_W'($urandom_range(DIM - 1));
	endfunction

	task automatic push_random(input int run_pct);
		logic [mmac_pkg::OP_W-1:0] op;
		logic [mmac_pkg::ROW_W-1:0] r, c;
		logic [mmac_pkg::VAL_W-1:0] v;
		logic [63:0] w;
		logic [31:0] w32;
		int sel, m, k, n;
		m = eff_dim(dim_m);
		k = eff_dim(dim_k);
		n = eff_dim(dim_n);
		w = {$urandom, $urandom};
		w32 = $urandom;
		v = w[mmac_pkg::VAL_W-1:0];
		r = pick_index(m);
		c = pick_index(n);
		if ($urandom_range(99) < run_pct) begin
			op = mmac_pkg::OP_RUN;
		end else begin
			sel = $urandom_range(99);
			if (sel < 30) op = mmac_pkg::OP_WRITE_A;
			else if (sel < 50) op = mmac_pkg::OP_WRITE_B;
			else if (sel < 62) op = mmac_pkg::OP_WRITE_C;
			else if (sel < 95) op = mmac_pkg::OP_READ_C;
			else op = mmac_pkg::OP_W'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
		end
		case (op)
			mmac_pkg::OP_WRITE_A, mmac_pkg::OP_WRITE_B: begin
				if (op == mmac_pkg::OP_WRITE_A) begin
					c = pick_index(k);
				end else begin
					r = pick_index(k);
				end
				sel = $urandom_range(9);
				if (sel == 1) begin
					// just around the Q8.8 limits
					v = w32[0] ? mmac_pkg::VAL_W'(32766 + $urandom_range(3)) :
						-mmac_pkg::VAL_W'(32767 + $urandom_range(3));
				end else if (sel > 1) begin
					v = {{32{w32[15]}}, w32[15:0]};
				end
			end
			mmac_pkg::OP_WRITE_C: begin
				sel = $urandom_range(9);
				if (sel == 2) begin
					v = C_MAX48 - mmac_pkg::VAL_W'($urandom_range(1 << 20));
				end else if (sel == 3) begin
					v = C_MIN48 + mmac_pkg::VAL_W'($urandom_range(1 << 20));
				end else if (sel > 3) begin
					v = {{16{w32[31]}}, w32};
				end
			end
			default: ;
		endcase
		push_item(op, r, c, v, 1'b0, '0);
	endtask

	// receiver stall pattern
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	// output transfers against the oldest expected read
	always @(posedge clk) begin
		c_read_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_reads.size() == 0) begin
				report_mismatch($sformatf("unexpected result transfer, tdata %h", m_tdata));
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata[3:0] !== want.row) begin
					report_mismatch($sformatf("out_row %0d, expected %0d", m_tdata[3:0], want.row));
				end
				if (m_tdata[7:4] !== want.col) begin
					report_mismatch($sformatf("out_col %0d, expected %0d", m_tdata[7:4], want.col));
				end
				if (m_tdata[55:8] !== want.value) begin
					report_mismatch($sformatf("c_value %h at (%0d,%0d), expected %h",
						m_tdata[55:8], want.row, want.col, want.value));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reads outstanding",
				cycle_count, pending_reads.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		int m, k, n, lim, run_pct;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// element stores power up undefined: write every entry once at full size
		for (int i = 0; i < DIM*DIM; i++) begin
			push_item(mmac_pkg::OP_WRITE_A, mmac_pkg::ROW_W'(i / DIM),
				mmac_pkg::ROW_W'(i % DIM), mmac_pkg::VAL_W'($urandom), 1'b0, '0);
		end
		for (int i = 0; i < DIM*DIM; i++) begin
			push_item(mmac_pkg::OP_WRITE_B, mmac_pkg::ROW_W'(i / DIM),
				mmac_pkg::ROW_W'(i % DIM), mmac_pkg::VAL_W'($urandom), 1'b0, '0);
		end
		for (int i = 0; i < DIM*DIM; i++) begin
			push_item(mmac_pkg::OP_WRITE_C, mmac_pkg::ROW_W'(i / DIM),
				mmac_pkg::ROW_W'(i % DIM), '0, 1'b0, '0);
		end
		wait_idle();

		set_dims(0, 1, 1, 4);
		foreach (directed_rows[i]) begin
			push_item(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
				directed_rows[i].value, directed_rows[i].typed, directed_rows[i].c_exp);
		end
		wait_idle();

		// random phases; idling swaps sides every four phases, last four run flat out
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph / 4)
				0: begin
					snd_idle_pct = 7;
					rcv_idle_pct = 79;
				end
				1: begin
					snd_idle_pct = 79;
					rcv_idle_pct = 7;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			lim = phase_rand[ph];
			if (lim != 0) begin
				m = $urandom_range(1, lim);
				k = $urandom_range(1, lim);
				n = $urandom_range(1, lim);
			end else begin
				m = phase_m[ph];
				k = phase_k[ph];
				n = phase_n[ph];
			end
			set_dims(m, k, n, phase_t[ph]);
			// keep runs of more than 256 MAC steps, such as full-size ones, rare
			run_pct = (eff_dim(dim_m) * eff_dim(dim_k) * eff_dim(dim_n) > 256) ? 1 : 8;
			repeat (PHASE_ITEMS) push_random(run_pct);
			wait_idle();
		end

		repeat (64) @(posedge clk);
		while (pending_reads.size() != 0) begin
			c_read_t left;
			left = pending_reads.pop_front();
			report_mismatch($sformatf("no result for read of (%0d,%0d)", left.row, left.col));
		end

		$display("Ran %0d input transfers: %0d C reads checked, %0d multiply-accumulate runs,",
			items_sent, reads_sent, runs_sent);
		$display("across %0d dimension settings with stalls on either side and none", settings_used);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- matrix_multiply_accumulate_core.f -----
rtl/mmac_pkg.sv
rtl/mmac_ram.sv
rtl/mmac_ctrl.sv
rtl/mmac_datapath.sv
rtl/matrix_multiply_accumulate_core.sv
test/matrix_multiply_accumulate_core_tb.sv
